// ===== rtl/dmm_pkg.sv =====
// ============================================================================
// dmm_pkg
// Shared widths, command and register codes, and control types for the
// dense matrix multiply block.
// ============================================================================
`default_nettype none

package dmm_pkg;

    // Transaction field widths.
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 16;
    localparam int PRODUCT_W = 38;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;   // zero the accumulator at the start of a read
        logic issue;   // a pair of store reads was issued this cycle
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dmm_req_if.sv =====
// ============================================================================
// dmm_req_if
// Request channel: load an element of A or B, or read an element of C.
// ============================================================================
`default_nettype none

interface dmm_req_if;
    logic                                valid;
    logic                                ready;
    logic        [dmm_pkg::CMD_W-1:0]    cmd;
    logic        [dmm_pkg::INDEX_W-1:0]  row;
    logic        [dmm_pkg::INDEX_W-1:0]  col;
    logic signed [dmm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input value,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/dmm_rsp_if.sv =====
// ============================================================================
// dmm_rsp_if
// Response channel: one element of the result matrix.
// ============================================================================
`default_nettype none

interface dmm_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dmm_pkg::PRODUCT_W-1:0]  product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmm_cfg_if.sv =====
// ============================================================================
// dmm_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface dmm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dmm_pkg::CFG_INDEX_W-1:0]     index;
    logic [dmm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dense_matrix_multiply.sv =====
// ============================================================================
// dense_matrix_multiply
// Dense matrix multiply C = A x B on signed Q8.8 elements, with A and B held
// in two on-chip element stores and C returned one element per read.
// ============================================================================
//
// Channel   Role    Payload                      Transaction moves
// -------   -----   --------------------------   -------------------------------
// req       sink    cmd, row, col, value         one load of A/B or one read of C
// rsp       source  product (signed Q22.16)      one element C[row][col]
// cfg       sink    index, data                  one size register write
//
// A load is written to its store when it is accepted. A read issues the
// paired store reads one inner term per cycle, and the terms then pass
// through the product register, the accumulate and the output register.
// With a zero inner_len the zero sum goes to the output register without
// any store reads. The sequencer returns to idle as the result is
// registered, so a new read waits until the last one is through. The
// sequential walk over the inner dimension through one multiplier bounds
// the rate. Requests are taken only while the sequencer is idle; a finished
// result waits in the output register while loads are still accepted.
// Reset clears the control state and sets all sizes to 64; the stores are
// not cleared and hold unknown data until loaded.
//
`default_nettype none

module dense_matrix_multiply #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dmm_req_if.sink    req,
    dmm_rsp_if.source  rsp,
    dmm_cfg_if.sink    cfg
);

    // Store geometry and the width used for all size comparisons.
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_DIM);
    localparam int CW    = ($clog2(MAX_DIM + 1) > dmm_pkg::CFG_DATA_W)
                           ? $clog2(MAX_DIM + 1) : dmm_pkg::CFG_DATA_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; indexes beyond
    // the register list are ignored.
    // ------------------------------------------------------------------
    logic [dmm_pkg::CFG_DATA_W-1:0] rows_a_reg;
    logic [dmm_pkg::CFG_DATA_W-1:0] inner_len_reg;
    logic [dmm_pkg::CFG_DATA_W-1:0] cols_b_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= dmm_pkg::SIZE_RESET;
            inner_len_reg <= dmm_pkg::SIZE_RESET;
            cols_b_reg    <= dmm_pkg::SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dmm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg.data;
                dmm_pkg::REG_INNER_LEN: inner_len_reg <= cfg.data;
                dmm_pkg::REG_COLS_B:    cols_b_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    // Sizes above the store dimension act as the store dimension.
    logic [CW-1:0] nr;
    logic [CW-1:0] nk;
    logic [CW-1:0] nc;

    always_comb
    begin
        nr = (CW'(rows_a_reg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(rows_a_reg);
        nk = (CW'(inner_len_reg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(inner_len_reg);
        nc = (CW'(cols_b_reg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(cols_b_reg);
    end

    // ------------------------------------------------------------------
    // Request decode.
    // ------------------------------------------------------------------
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [KW-1:0]         row_reg;
    logic [KW-1:0]         col_reg;
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         k_next;

    logic                  req_fire;
    logic                  row_in_a;
    logic                  col_in_k;
    logic                  row_in_k;
    logic                  col_in_c;
    logic                  load_a;
    logic                  load_b;
    logic                  start_read;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_elem;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid & req.ready;

    assign row_in_a = CW'(req.row) < nr;
    assign row_in_k = CW'(req.row) < nk;
    assign col_in_k = CW'(req.col) < nk;
    assign col_in_c = CW'(req.col) < nc;

    always_comb
    begin
        load_a     = 1'b0;
        load_b     = 1'b0;
        start_read = 1'b0;
        if (req_fire)
        begin
            case (req.cmd)
                dmm_pkg::CMD_LOAD_A: load_a     = row_in_a & col_in_k;
                dmm_pkg::CMD_LOAD_B: load_b     = row_in_k & col_in_c;
                dmm_pkg::CMD_READ:   start_read = row_in_a & col_in_c;
                default: ;
            endcase
        end
    end

    // Both stores use row-major addressing: row * MAX_DIM + col. Indexes
    // that reach this point are below MAX_DIM, so the narrowing is exact.
    assign wr_addr = AW'(AW'(req.row) * AW'(MAX_DIM)) + AW'(req.col);
    // The loaded value is wrapped to the element width with sign extension.
    assign wr_elem = ELEM_WIDTH'(req.value);

    // ------------------------------------------------------------------
    // Read sequencer: walk k over the inner dimension, one pair of store
    // reads per cycle, then wait for the multiply-accumulate to drain.
    // ------------------------------------------------------------------
    dmm_pkg::mac_ctl_t     mac_ctl;
    logic                  mac_busy;
    logic signed [dmm_pkg::PRODUCT_W-1:0] mac_acc;
    logic                  issue;
    logic                  last_k;
    logic                  deliver;
    logic                  slot_free;
    logic [AW-1:0]         a_rd_addr;
    logic [AW-1:0]         b_rd_addr;
    logic [ELEM_WIDTH-1:0] a_rd_data;
    logic [ELEM_WIDTH-1:0] b_rd_data;

    logic                                 rsp_valid_reg;
    logic signed [dmm_pkg::PRODUCT_W-1:0] rsp_product_reg;

    assign issue     = (state_reg == ST_ISSUE);
    assign last_k    = (CW'(k_reg) == (nk - CW'(1)));
    assign slot_free = ~rsp_valid_reg | rsp.ready;
    assign deliver   = (state_reg == ST_DRAIN) & ~mac_busy & slot_free;

    assign a_rd_addr = AW'(AW'(row_reg) * AW'(MAX_DIM)) + AW'(k_reg);
    assign b_rd_addr = AW'(AW'(k_reg) * AW'(MAX_DIM)) + AW'(col_reg);

    assign mac_ctl.clear = start_read;
    assign mac_ctl.issue = issue;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (start_read)
                begin
                    // An empty inner dimension gives a zero sum right away.
                    state_next = (nk == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                k_next = k_reg + KW'(1);
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (deliver)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_read)
        begin
            row_reg <= KW'(req.row);
            col_reg <= KW'(req.col);
        end
    end

    // ------------------------------------------------------------------
    // Element stores and the multiply-accumulate unit.
    // ------------------------------------------------------------------
    dmm_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (load_a),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    dmm_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (load_b),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    dmm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .busy   (mac_busy),
        .acc    (mac_acc)
    );

    // ------------------------------------------------------------------
    // Output register. A finished sum moves in once the previous result
    // has been taken, or in the same cycle that it is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (deliver)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            rsp_product_reg <= mac_acc;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.product = rsp_product_reg;

endmodule

`default_nettype wire

// ===== rtl/dmm_store.sv =====
// ============================================================================
// dmm_store
// Element store: synchronous memory with one write port and one read port,
// read data registered.
// ============================================================================
`default_nettype none

module dmm_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmm_mac.sv =====
// ============================================================================
// dmm_mac
// Multiply-accumulate unit: registers the product of the two store outputs,
// then adds it into a wrapping Q22.16 accumulator.
// ============================================================================
`default_nettype none

module dmm_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dmm_pkg::mac_ctl_t                     ctl,
    input  wire logic        [ELEM_WIDTH-1:0]          a_data,
    input  wire logic        [ELEM_WIDTH-1:0]          b_data,
    output logic                                       busy,
    output logic signed      [dmm_pkg::PRODUCT_W-1:0]  acc
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic                                   data_vld_reg;
    logic                                   prod_vld_reg;
    logic signed [PROD_W-1:0]               prod_reg;
    logic signed [dmm_pkg::PRODUCT_W-1:0]   acc_reg;
    logic signed [dmm_pkg::PRODUCT_W-1:0]   acc_next;

    // Store data arrives in the cycle after the issue strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            data_vld_reg <= ctl.issue;
            prod_vld_reg <= data_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_vld_reg)
        begin
            prod_reg <= PROD_W'($signed(a_data)) * PROD_W'($signed(b_data));
        end
    end

    // The sum wraps modulo 2^PRODUCT_W; the product is sign-extended or cut.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + dmm_pkg::PRODUCT_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign busy = data_vld_reg | prod_vld_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire
